FILE: rtl/core/polygon_revolution_volume_top_defines.svh
// Assertion macros shared by the polygon revolution volume RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef POLYGON_REVOLUTION_VOLUME_TOP_DEFINES_SVH
`define POLYGON_REVOLUTION_VOLUME_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define POLYREV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define POLYREV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/polyrev_pkg.sv
// Shared constants and the edge record for the polygon revolution volume block.
// No dependencies.
package polyrev_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MIN_VERTICES = 3;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

  localparam int COORD_W = 16;
  localparam int SCALE_W = 17;
  localparam int AREA_W  = 40;
  localparam int MOM_W   = 57;
  localparam int VOL_W   = 58;

  // Edge queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Configuration map
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_REVOLUTION_SCALE = 1'b0;

  // One edge a -> b, plus the closing tags when it is the ring's last edge
  typedef struct packed {
    logic signed [COORD_W-1:0] xa;
    logic signed [COORD_W-1:0] ya;
    logic signed [COORD_W-1:0] xb;
    logic signed [COORD_W-1:0] yb;
    logic                      close;
    logic                      few;
    logic                      too_many;
  } edge_t;

endpackage

FILE: rtl/core/polyrev_front.sv
// Front end: takes vertices, tracks first/prev vertex and count, emits edges.
// Depends on polyrev_pkg.
module polyrev_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [polyrev_pkg::COORD_W-1:0] in_x,
  input  logic signed [polyrev_pkg::COORD_W-1:0] in_y,
  input  logic                                  in_last,
  output logic                                  q_wr,
  output polyrev_pkg::edge_t                    q_data,
  input  logic                                  q_full
);

  logic [polyrev_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                                  over_r, over_nxt;
  logic signed [polyrev_pkg::COORD_W-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [polyrev_pkg::COORD_W-1:0] first_x_nxt, first_y_nxt, prev_x_nxt, prev_y_nxt;
  logic                                  pend_r;
  polyrev_pkg::edge_t                    pend_edge_r;

  logic               take, room, need_a;
  polyrev_pkg::edge_t edge_a, edge_b;

  assign full = pend_r | q_full;
  assign take = push & ~full;
  assign room = cnt_r < polyrev_pkg::CNT_W'(polyrev_pkg::MAX_VERTICES);
  assign need_a = room & (cnt_r != '0);

  always_comb begin
    cnt_nxt     = room ? cnt_r + 1'b1 : cnt_r;
    over_nxt    = over_r | ~room;
    first_x_nxt = (room && cnt_r == '0) ? in_x : first_x_r;
    first_y_nxt = (room && cnt_r == '0) ? in_y : first_y_r;
    prev_x_nxt  = room ? in_x : prev_x_r;
    prev_y_nxt  = room ? in_y : prev_y_r;

    edge_a.xa       = prev_x_r;
    edge_a.ya       = prev_y_r;
    edge_a.xb       = in_x;
    edge_a.yb       = in_y;
    edge_a.close    = 1'b0;
    edge_a.few      = 1'b0;
    edge_a.too_many = 1'b0;

    // closing edge back to the first vertex
    edge_b.xa       = prev_x_nxt;
    edge_b.ya       = prev_y_nxt;
    edge_b.xb       = first_x_nxt;
    edge_b.yb       = first_y_nxt;
    edge_b.close    = 1'b1;
    edge_b.few      = cnt_nxt < polyrev_pkg::CNT_W'(polyrev_pkg::MIN_VERTICES);
    edge_b.too_many = over_nxt;
  end

  always_comb begin
    if (pend_r) begin
      q_wr   = ~q_full;
      q_data = pend_edge_r;
    end else begin
      q_wr   = take & (need_a | in_last);
      q_data = need_a ? edge_a : edge_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      over_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      if (pend_r && !q_full) begin
        pend_r <= 1'b0;
      end
      if (take) begin
        if (in_last) begin
          cnt_r  <= '0;
          over_r <= 1'b0;
          if (need_a) begin
            pend_r <= 1'b1;
          end
        end else begin
          cnt_r  <= cnt_nxt;
          over_r <= over_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      first_x_r   <= first_x_nxt;
      first_y_r   <= first_y_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      pend_edge_r <= edge_b;
    end
  end

endmodule

FILE: rtl/core/polyrev_fifo.sv
// Short edge queue between the front and back parts.
// Depends on polyrev_pkg.
module polyrev_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  polyrev_pkg::edge_t wr_data,
  output logic               full,
  input  logic               rd_en,
  output polyrev_pkg::edge_t rd_data,
  output logic               empty
);

  polyrev_pkg::edge_t              mem_r [polyrev_pkg::FIFO_DEPTH];
  logic [polyrev_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [polyrev_pkg::FIFO_AW:0]   cnt_r;

  assign full    = cnt_r == (polyrev_pkg::FIFO_AW+1)'(polyrev_pkg::FIFO_DEPTH);
  assign empty   = cnt_r == '0;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/core/polyrev_back.sv
// Back end: per-edge product pipeline, shoelace/moment accumulation, volume scaling.
// Depends on polyrev_pkg and polygon_revolution_volume_top_defines.svh.
`include "polygon_revolution_volume_top_defines.svh"

module polyrev_back (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [polyrev_pkg::SCALE_W-1:0]        scale,
  output logic                                   q_rd,
  input  polyrev_pkg::edge_t                     q_data,
  input  logic                                   q_empty,
  input  logic                                   pop,
  output logic                                   empty,
  output logic signed [polyrev_pkg::VOL_W-1:0]   out_volume,
  output logic signed [polyrev_pkg::AREA_W-1:0]  out_twice_area,
  output logic                                   out_degenerate,
  output logic                                   out_too_many
);

  typedef struct packed {
    logic close;
    logic few;
    logic too_many;
  } tag_t;

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, out_valid_r;

  // stage 1: cross products and y sum
  logic signed [polyrev_pkg::COORD_W-1:0] xa, ya, xb, yb;
  logic signed [31:0] p1_r, p2_r;
  logic signed [16:0] ysum1_r, ysum2_r;
  tag_t               t1_r, t2_r, t3_r;
  // stage 2: cross term
  logic signed [32:0] c2_r, c3_r;
  // stage 3: moment term
  logic signed [49:0] m3_r;
  // stage 4: accumulators and closed sums
  logic signed [polyrev_pkg::AREA_W-1:0] area_acc_r, area_sum;
  logic signed [polyrev_pkg::MOM_W-1:0]  mom_acc_r, mom_sum, mom_neg;
  logic signed [polyrev_pkg::AREA_W-1:0] area4_r, area5_r, area6_r, area7_r;
  logic signed [polyrev_pkg::MOM_W-1:0]  mom4_r;
  logic degen4_r, degen5_r, degen6_r, degen7_r;
  logic tm4_r, tm5_r, tm6_r, tm7_r;
  // stage 5..7: magnitude, partial products, recombine
  logic [55:0]                  mag5_r;
  logic                         neg5_r, neg6_r, neg7_r;
  logic [48:0]                  lo6_r;
  logic [40:0]                  hi6_r;
  logic [polyrev_pkg::VOL_W-1:0] q7_r;
  logic                         rem7_r;
  logic [polyrev_pkg::VOL_W-1:0] vol;
  // result register
  logic signed [polyrev_pkg::VOL_W-1:0]  out_volume_r;
  logic signed [polyrev_pkg::AREA_W-1:0] out_twice_area_r;
  logic                                  out_degen_r, out_tm_r;

  // whole pipe holds while a result waits unpopped
  assign adv   = ~out_valid_r | pop;
  assign q_rd  = adv & ~q_empty;
  assign empty = ~out_valid_r;

  assign xa = q_data.xa;
  assign ya = q_data.ya;
  assign xb = q_data.xb;
  assign yb = q_data.yb;

  assign area_sum = area_acc_r + {{7{c3_r[32]}}, c3_r};
  assign mom_sum  = mom_acc_r + {{7{m3_r[49]}}, m3_r};
  assign mom_neg  = -mom4_r;

  always_comb begin
    if (degen7_r) begin
      vol = '0;
    end else if (neg7_r) begin
      vol = rem7_r ? ~q7_r : -q7_r;  // floor of a negative quotient
    end else begin
      vol = q7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
      area_acc_r  <= '0;
      mom_acc_r   <= '0;
    end else if (adv) begin
      v1_r        <= ~q_empty;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r & t3_r.close;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      out_valid_r <= v7_r;
      if (v3_r) begin
        if (t3_r.close) begin
          area_acc_r <= '0;
          mom_acc_r  <= '0;
        end else begin
          area_acc_r <= area_sum;
          mom_acc_r  <= mom_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r    <= xa * yb;
      p2_r    <= ya * xb;
      ysum1_r <= $signed({ya[15], ya}) + $signed({yb[15], yb});
      t1_r    <= '{close: q_data.close, few: q_data.few, too_many: q_data.too_many};

      c2_r    <= $signed({p1_r[31], p1_r}) - $signed({p2_r[31], p2_r});
      ysum2_r <= ysum1_r;
      t2_r    <= t1_r;

      m3_r <= ysum2_r * c2_r;
      c3_r <= c2_r;
      t3_r <= t2_r;

      area4_r  <= area_sum;
      mom4_r   <= mom_sum;
      degen4_r <= t3_r.few | (area_sum == '0);
      tm4_r    <= t3_r.too_many;

      mag5_r   <= mom4_r[polyrev_pkg::MOM_W-1] ? mom_neg[55:0] : mom4_r[55:0];
      neg5_r   <= mom4_r[polyrev_pkg::MOM_W-1] ^ area4_r[polyrev_pkg::AREA_W-1];
      area5_r  <= area4_r;
      degen5_r <= degen4_r;
      tm5_r    <= tm4_r;

      lo6_r    <= mag5_r[31:0] * scale;
      hi6_r    <= mag5_r[55:32] * scale;
      neg6_r   <= neg5_r;
      area6_r  <= area5_r;
      degen6_r <= degen5_r;
      tm6_r    <= tm5_r;

      q7_r     <= {1'b0, hi6_r, 16'b0} + {25'b0, lo6_r[48:16]};
      rem7_r   <= |lo6_r[15:0];
      neg7_r   <= neg6_r;
      area7_r  <= area6_r;
      degen7_r <= degen6_r;
      tm7_r    <= tm6_r;

      out_volume_r     <= vol;
      out_twice_area_r <= area7_r;
      out_degen_r      <= degen7_r;
      out_tm_r         <= tm7_r;
    end
  end

  assign out_volume     = out_volume_r;
  assign out_twice_area = out_twice_area_r;
  assign out_degenerate = out_degen_r;
  assign out_too_many   = out_tm_r;

  `POLYREV_ASSERT_NOW(a_degen_zero_vol, out_valid_r && out_degen_r,
                      out_volume_r == '0, "degenerate result carries a volume")
  `POLYREV_ASSERT_NOW(a_area_nonzero, out_valid_r && !out_degen_r,
                      out_twice_area_r != '0, "zero area not flagged degenerate")
  `POLYREV_ASSERT_NOW(a_acc_cleared, v4_r, area_acc_r == '0 && mom_acc_r == '0,
                      "sums not cleared after ring close")
  `POLYREV_ASSERT_NEXT(a_stall_hold, out_valid_r && !pop,
                       v7_r == $past(v7_r) && $stable(out_volume_r),
                       "pipe moved while result stalled")

endmodule

FILE: rtl/core/polygon_revolution_volume_top.sv
// Polygon volume of revolution (Pappus), top level with configuration port.
// Depends on polyrev_pkg, polyrev_front, polyrev_fifo, polyrev_back.
//
// Vertices enter one per transfer on the push/full side; the transfer whose
// last_vertex is set closes the ring back to the first vertex and yields one
// result on the empty/pop side: the shoelace sum (twice the signed area) and
// the volume floor(sign(area) * moment * revolution_scale / 2^16), where the
// moment is sum((ya+yb)*(xa*yb-ya*xb)). Fewer than three vertices or a zero
// area gives volume 0 with degenerate set; vertices beyond 64 in one ring are
// dropped and flag too_many. Rate: one vertex per cycle while the edge queue
// has room; a closing vertex that follows at least one earlier vertex within
// the limit raises full, since the front queues its last edge, then its
// closing edge once the queue has room; a single-vertex ring or a closing
// vertex past the limit issues only the closing edge. The back part
// retires one edge per cycle through its accumulator while no result waits
// unpopped; with the queue and back part idle, empty falls once the closing
// edge's result is registered. The front keeps accepting into a four-entry
// edge queue while a result waits to be popped; the back holds until it is.
// revolution_scale sits at byte address 0 (17 bits, unsigned Q1.16); the
// user must write it only while the block is idle; it does not enforce this.
module polygon_revolution_volume_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // vertex input
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [polyrev_pkg::COORD_W-1:0] in_vertex_x,
  input  logic signed [polyrev_pkg::COORD_W-1:0] in_vertex_y,
  input  logic                                   in_last_vertex,
  // result output
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [polyrev_pkg::VOL_W-1:0]   out_volume,
  output logic signed [polyrev_pkg::AREA_W-1:0]  out_twice_area,
  output logic                                   out_degenerate,
  output logic                                   out_too_many,
  // configuration
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [polyrev_pkg::PADDR_W-1:0]        paddr,
  input  logic [polyrev_pkg::PDATA_W-1:0]        pwdata,
  output logic [polyrev_pkg::PDATA_W-1:0]        prdata,
  output logic                                   pready
);

  logic [polyrev_pkg::SCALE_W-1:0] scale_r;
  logic                            reg_hit;

  logic               e_wr, e_full, e_rd, e_empty;
  polyrev_pkg::edge_t e_wdata, e_rdata;

  // Configuration: zero-wait APB, word index from paddr[2]
  assign pready  = 1'b1;
  assign reg_hit = paddr[polyrev_pkg::PADDR_W-1] == polyrev_pkg::REG_REVOLUTION_SCALE;
  assign prdata  = reg_hit
                   ? {{(polyrev_pkg::PDATA_W-polyrev_pkg::SCALE_W){1'b0}}, scale_r}
                   : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      scale_r <= pwdata[polyrev_pkg::SCALE_W-1:0];
    end
  end

  // Front: vertex bookkeeping, one edge per cycle into the queue unless full
  polyrev_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_x    (in_vertex_x),
    .in_y    (in_vertex_y),
    .in_last (in_last_vertex),
    .q_wr    (e_wr),
    .q_data  (e_wdata),
    .q_full  (e_full)
  );

  polyrev_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (e_wr),
    .wr_data (e_wdata),
    .full    (e_full),
    .rd_en   (e_rd),
    .rd_data (e_rdata),
    .empty   (e_empty)
  );

  // Back: products, accumulation, volume scaling, result register
  polyrev_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .scale          (scale_r),
    .q_rd           (e_rd),
    .q_data         (e_rdata),
    .q_empty        (e_empty),
    .pop            (pop),
    .empty          (empty),
    .out_volume     (out_volume),
    .out_twice_area (out_twice_area),
    .out_degenerate (out_degenerate),
    .out_too_many   (out_too_many)
  );

endmodule

FILE: bench/tb_polygon_revolution_volume_top.sv
// Self-checking bench for polygon_revolution_volume_top: random polygon rings, APB scale writes.
// Depends on polyrev_pkg and the polygon_revolution_volume_top RTL; needs nothing else.
`timescale 1ns / 100ps

module tb_polygon_revolution_volume_top;

  // ---------------------------------------------------------------------------
  // Bench constants
  // ---------------------------------------------------------------------------
  localparam int MAX_SCALE      = (1 << polyrev_pkg::SCALE_W) - 1;
  localparam int SETTLE_CYCLES  = 30;    // well past the close-to-result path through the block
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off to back the block up
  localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transfer

  localparam logic [polyrev_pkg::PADDR_W-1:0] SCALE_ADDR =
    polyrev_pkg::PADDR_W'(4 * int'(polyrev_pkg::REG_REVOLUTION_SCALE));
  localparam logic [polyrev_pkg::PADDR_W-1:0] UNMAPPED_ADDR =
    polyrev_pkg::PADDR_W'(4 * (int'(polyrev_pkg::REG_REVOLUTION_SCALE) + 1));

  typedef enum {COORD_FULL, COORD_NEAR_ZERO, COORD_EXTREME} coord_span_e;

  typedef struct packed {
    logic signed [polyrev_pkg::COORD_W-1:0] x;
    logic signed [polyrev_pkg::COORD_W-1:0] y;
    logic                                   last;
  } vertex_t;

  typedef struct packed {
    logic signed [polyrev_pkg::VOL_W-1:0]  volume;
    logic signed [polyrev_pkg::AREA_W-1:0] twice_area;
    logic                                  degenerate;
    logic                                  too_many;
  } swept_result_t;

  // ---------------------------------------------------------------------------
  // DUT signals, inputs at known values from time zero
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                                   push           = 1'b0;
  logic                                   full;
  logic signed [polyrev_pkg::COORD_W-1:0] in_vertex_x    = '0;
  logic signed [polyrev_pkg::COORD_W-1:0] in_vertex_y    = '0;
  logic                                   in_last_vertex = 1'b0;

  logic                                   empty;
  logic                                   pop            = 1'b0;
  logic signed [polyrev_pkg::VOL_W-1:0]   out_volume;
  logic signed [polyrev_pkg::AREA_W-1:0]  out_twice_area;
  logic                                   out_degenerate;
  logic                                   out_too_many;

  logic                                   psel    = 1'b0;
  logic                                   penable = 1'b0;
  logic                                   pwrite  = 1'b0;
  logic [polyrev_pkg::PADDR_W-1:0]        paddr   = '0;
  logic [polyrev_pkg::PDATA_W-1:0]        pwdata  = '0;
  logic [polyrev_pkg::PDATA_W-1:0]        prdata;
  logic                                   pready;

  polygon_revolution_volume_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_last_vertex (in_last_vertex),
    .empty          (empty),
    .pop            (pop),
    .out_volume     (out_volume),
    .out_twice_area (out_twice_area),
    .out_degenerate (out_degenerate),
    .out_too_many   (out_too_many),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  vertex_t       vertex_feed[$];     // vertices waiting for their input transfer
  swept_result_t swept_expect[$];    // predicted results, oldest first
  int            failures = 0;

  // Receiver hold-off handshake: the stimulus bumps the request count, the
  // monitor serves it and counts the hold itself.
  int stalls_asked  = 0;
  int stalls_served = 0;

  int corner_coords[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

  // ---------------------------------------------------------------------------
  // Predictor: ring accumulation, mirrors the block's own state
  // ---------------------------------------------------------------------------
  logic [polyrev_pkg::SCALE_W-1:0]        sweep_scale   = '0;
  logic signed [polyrev_pkg::COORD_W-1:0] ring_first_x  = '0;
  logic signed [polyrev_pkg::COORD_W-1:0] ring_first_y  = '0;
  logic signed [polyrev_pkg::COORD_W-1:0] ring_prev_x   = '0;
  logic signed [polyrev_pkg::COORD_W-1:0] ring_prev_y   = '0;
  longint                                 area_sum      = 0;  // fits 40 bits, count is bounded
  longint                                 moment_sum    = 0;  // fits 57 bits
  int                                     ring_count    = 0;
  bit                                     ring_overflow = 1'b0;

  function automatic void add_edge(longint xa, longint ya, longint xb, longint yb);
    longint cross_term;
    cross_term = xa * yb - ya * xb;
    area_sum   += cross_term;
    moment_sum += (ya + yb) * cross_term;
  endfunction

  function automatic void accumulate_vertex(vertex_t v);
    logic signed [127:0] wide_moment;
    logic signed [127:0] wide_volume;
    swept_result_t       r;
    // a full ring drops the vertex but still honors its last flag
    if (ring_count >= polyrev_pkg::MAX_VERTICES) begin
      ring_overflow = 1'b1;
    end else begin
      if (ring_count == 0) begin
        ring_first_x = v.x;
        ring_first_y = v.y;
      end else begin
        add_edge(ring_prev_x, ring_prev_y, v.x, v.y);
      end
      ring_prev_x = v.x;
      ring_prev_y = v.y;
      ring_count++;
    end
    if (v.last) begin
      if (ring_count > 0)
        add_edge(ring_prev_x, ring_prev_y, ring_first_x, ring_first_y);
      r.degenerate = (ring_count < polyrev_pkg::MIN_VERTICES) || (area_sum == 0);
      r.twice_area = polyrev_pkg::AREA_W'(area_sum);
      r.too_many   = ring_overflow;
      r.volume     = '0;
      if (!r.degenerate) begin
        wide_moment = moment_sum;
        if (area_sum < 0)
          wide_moment = -wide_moment;
        // arithmetic shift gives floor rounding for negative volumes
        wide_volume = (wide_moment * $signed({111'd0, sweep_scale})) >>> 16;
        r.volume    = wide_volume[polyrev_pkg::VOL_W-1:0];
      end
      swept_expect  = {swept_expect, r};
      ring_count    = 0;
      ring_overflow = 1'b0;
      area_sum      = 0;
      moment_sum    = 0;
      ring_first_x  = '0;
      ring_first_y  = '0;
      ring_prev_x   = '0;
      ring_prev_y   = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic void queue_vertex(int x, int y, bit last);
    vertex_t v;
    v.x    = polyrev_pkg::COORD_W'(x);
    v.y    = polyrev_pkg::COORD_W'(y);
    v.last = last;
    vertex_feed = {vertex_feed, v};
  endfunction

  function automatic int pick_coord(coord_span_e span);
    case (span)
      COORD_NEAR_ZERO: return int'($urandom_range(0, 6)) - 3;
      COORD_EXTREME:   return corner_coords[$urandom_range(0, 6)];
      default:         return int'($signed(16'($urandom)));
    endcase
  endfunction

  // flat rings keep one ordinate for every vertex, so the area sums to zero
  function automatic void queue_ring(int count, coord_span_e span, bit flat);
    int level;
    level = pick_coord(span);
    for (int i = 0; i < count; i++)
      queue_vertex(pick_coord(span), flat ? level : pick_coord(span), i == count - 1);
  endfunction

  // Mostly proper polygons with random content; the rest is short broken
  // rings, flat rings and rings around the vertex limit.
  function automatic void queue_random_rings(int target);
    int          queued;
    int          pick;
    int          count;
    int          span_pick;
    bit          flat;
    coord_span_e span;
    queued = 0;
    while (queued < target) begin
      pick      = $urandom_range(0, 99);
      span_pick = $urandom_range(0, 9);
      flat      = 1'b0;
      if (span_pick < 7)
        span = COORD_FULL;
      else if (span_pick < 9)
        span = COORD_NEAR_ZERO;
      else
        span = COORD_EXTREME;
      if (pick < 70) begin
        count = $urandom_range(3, 10);
      end else if (pick < 80) begin
        count = $urandom_range(1, 2);
      end else if (pick < 90) begin
        count = $urandom_range(11, 40);
      end else if (pick < 95) begin
        count = $urandom_range(3, 8);
        flat  = 1'b1;
      end else begin
        count = $urandom_range(polyrev_pkg::MAX_VERTICES - 4, polyrev_pkg::MAX_VERTICES + 6);
      end
      queue_ring(count, span, flat);
      queued += count;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port: setup cycle, then access cycle
  // ---------------------------------------------------------------------------
  task automatic apb_transfer(input bit is_write,
                              input logic [polyrev_pkg::PADDR_W-1:0] addr,
                              input logic [polyrev_pkg::PDATA_W-1:0] wdata,
                              output logic [polyrev_pkg::PDATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // pready is tied high: this edge completes the access
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_scale();
    logic [polyrev_pkg::PDATA_W-1:0] readback;
    apb_transfer(1'b0, SCALE_ADDR, '0, readback);
    if (readback !== polyrev_pkg::PDATA_W'(sweep_scale)) begin
      $error("revolution_scale readback: expected %0d, got %0d", sweep_scale, readback);
      failures++;
    end
  endtask

  // bits above the register width are dropped by the block
  task automatic set_scale(input logic [polyrev_pkg::PDATA_W-1:0] value);
    logic [polyrev_pkg::PDATA_W-1:0] unused;
    apb_transfer(1'b1, SCALE_ADDR, value, unused);
    sweep_scale = value[polyrev_pkg::SCALE_W-1:0];
    check_scale();
  endtask

  // Idle point for register writes: feed drained, every result popped, then
  // a settle period in case a dropped or open-ring vertex is still in flight.
  task automatic wait_idle();
    while (vertex_feed.size() != 0 || push || swept_expect.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Vertex driver: bursts of random length, random gaps in between.
  // The transfer is recorded in the predictor at the edge where it happens.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin : vertex_driver
    logic next_push;
    int   gap_pick;
    if (rst_n) begin
      next_push = push;
      if (push && !full) begin
        accumulate_vertex(vertex_feed.pop_front());
        next_push = 1'b0;
      end
      // a stalled vertex stays on the port untouched
      if (!next_push) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (vertex_feed.size() > 0) begin
          next_push = 1'b1;
          in_vertex_x    <= vertex_feed[0].x;
          in_vertex_y    <= vertex_feed[0].y;
          in_last_vertex <= vertex_feed[0].last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_pick   = $urandom_range(0, 99);
            if (gap_pick < 50)
              gap_left = 0;
            else if (gap_pick < 85)
              gap_left = $urandom_range(1, 3);
            else
              gap_left = $urandom_range(4, 20);
          end
        end
      end
      push <= next_push;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and receiver: every result transfer is checked against the
  // oldest prediction; pop follows a random 8-bit pattern, redrawn whenever its
  // window runs out, unless a long hold-off is in progress.
  // ---------------------------------------------------------------------------
  logic [7:0] pop_pattern   = 8'hFF;
  logic [2:0] pattern_phase = '0;
  int         pattern_left  = 0;
  int         hold_left     = 0;

  always @(posedge clk) begin : result_monitor
    swept_result_t want;
    logic          next_pop;
    if (rst_n) begin
      if (pop && !empty) begin
        if (swept_expect.size() == 0) begin
          $error("result transfer with none expected: volume %0d, twice_area %0d",
                 out_volume, out_twice_area);
          failures++;
        end else begin
          want = swept_expect.pop_front();
          if (out_volume !== want.volume) begin
            $error("volume: expected %0d, got %0d", want.volume, out_volume);
            failures++;
          end
          if (out_twice_area !== want.twice_area) begin
            $error("twice_area: expected %0d, got %0d", want.twice_area, out_twice_area);
            failures++;
          end
          if (out_degenerate !== want.degenerate) begin
            $error("degenerate: expected %0d, got %0d", want.degenerate, out_degenerate);
            failures++;
          end
          if (out_too_many !== want.too_many) begin
            $error("too_many: expected %0d, got %0d", want.too_many, out_too_many);
            failures++;
          end
        end
      end
      if (stalls_asked != stalls_served) begin
        stalls_served++;
        hold_left = HOLD_CYCLES;
      end
      if (pattern_left == 0) begin
        pattern_left = 64;
        // a quarter of the windows never stall; others set at least one pop bit
        pop_pattern  = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end
      pattern_left--;
      pattern_phase = pattern_phase + 3'd1;
      if (hold_left > 0) begin
        hold_left--;
        next_pop = 1'b0;
      end else begin
        next_pop = pop_pattern[pattern_phase];
      end
      pop <= next_pop;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transfer on any port ends the run
  // ---------------------------------------------------------------------------
  int stuck_cycles = 0;

  always @(posedge clk) begin : watchdog
    if ((push && !full) || (pop && !empty) || (psel && penable)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence: idle-separated phases, all but the back-pressure one with a scale setting each
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [polyrev_pkg::PDATA_W-1:0] unused;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_scale();  // reset value

    // Directed rings at the largest scale
    set_scale(polyrev_pkg::PDATA_W'(MAX_SCALE));
    queue_vertex(123, -456, 1'b1);                // single vertex, closes onto itself
    queue_vertex(32767, 32767, 1'b0);             // two vertices
    queue_vertex(-32768, -32768, 1'b1);
    queue_vertex(-32768, -32768, 1'b0);           // widest triangle, positive area
    queue_vertex(32767, -32768, 1'b0);
    queue_vertex(32767, 32767, 1'b1);
    queue_vertex(32767, 32767, 1'b0);             // same triangle, clockwise
    queue_vertex(32767, -32768, 1'b0);
    queue_vertex(-32768, -32768, 1'b1);
    queue_vertex(-3, -3, 1'b0);                   // collinear, zero area
    queue_vertex(1, 1, 1'b0);
    queue_vertex(5, 5, 1'b1);
    queue_vertex(0, -100, 1'b0);                  // square below the axis
    queue_vertex(200, -100, 1'b0);
    queue_vertex(200, -300, 1'b0);
    queue_vertex(0, -300, 1'b1);
    wait_idle();

    // Zero scale; rings right at, one past and two past the vertex limit
    set_scale('0);
    queue_ring(polyrev_pkg::MAX_VERTICES, COORD_FULL, 1'b0);
    queue_ring(polyrev_pkg::MAX_VERTICES + 1, COORD_FULL, 1'b0);
    queue_ring(polyrev_pkg::MAX_VERTICES + 2, COORD_EXTREME, 1'b0);
    queue_random_rings(150);
    wait_idle();

    // Unit scale, written with junk above the register width
    set_scale({15'($urandom) | 15'h1, 17'h10000});
    queue_random_rings(350);
    wait_idle();

    // Write to an unmapped address must leave the scale alone, then
    // back-pressure: receiver holds off while triangles keep coming in
    apb_transfer(1'b1, UNMAPPED_ADDR, $urandom, unused);
    check_scale();
    stalls_asked <= stalls_asked + 1;
    for (int i = 0; i < 150; i++)
      queue_ring(3, COORD_FULL, 1'b0);
    wait_idle();

    set_scale(polyrev_pkg::PDATA_W'($urandom_range(0, MAX_SCALE)));
    queue_random_rings(350);
    wait_idle();

    // Smallest nonzero scale
    set_scale(polyrev_pkg::PDATA_W'(1));
    queue_random_rings(300);
    wait_idle();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && swept_expect.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
